/* rtl/core/sebd_pkg.sv */
// Shared types and constants of the spectral energy burst detector.
package sebd_pkg;

    localparam logic [16:0] ONE_Q16       = 17'd65536;
    localparam logic [31:0] SIGMA_FLOOR   = 32'd6554;
    localparam logic [47:0] VAR_RESET     = 48'd6553600;
    localparam logic [31:0] SIGMA_RESET   = 32'd655360;
    localparam logic [47:0] MAX48         = 48'hFFFF_FFFF_FFFF;

    localparam int MUL_A_W = 48;
    localparam int MUL_B_W = 17;
    localparam int ACC_W   = 66;

    localparam logic [2:0] CFG_JUMP_THRESHOLD = 3'd0;
    localparam logic [2:0] CFG_LATCH_DURATION = 3'd1;
    localparam logic [2:0] CFG_LEAK_FACTOR    = 3'd2;
    localparam logic [2:0] CFG_GRADIENT_SPAN  = 3'd3;
    localparam logic [2:0] CFG_EWMA_WEIGHT    = 3'd4;
    localparam logic [2:0] CFG_DANGER_GAIN    = 3'd5;
    localparam logic [2:0] CFG_PUBLISH_GAP    = 3'd6;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MOD,
        ST_LATCH,
        ST_GRAD,
        ST_ZTEST,
        ST_MEAN_B,
        ST_MEAN_C,
        ST_DSQ_A,
        ST_DSQ_B,
        ST_DSQ_C,
        ST_VAR_A,
        ST_VAR_B,
        ST_VAR_C,
        ST_SQRT,
        ST_THR,
        ST_THR2,
        ST_OUT
    } seq_state_t;

    typedef struct packed {
        logic en;
        logic load;
        logic shift16;
    } mac_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sqrt_stat_t;

endpackage

/* rtl/core/sebd_ram.sv */
// Generic single-port-write, registered-read RAM.
module sebd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/sebd_mac.sv */
// Shared 48x17 multiplier with registered accumulator.
module sebd_mac
    import sebd_pkg::*;
(
    input  logic               clk,
    input  mac_ctrl_t          ctrl,
    input  logic [MUL_A_W-1:0] a,
    input  logic [MUL_B_W-1:0] b,
    output logic [ACC_W-1:0]   acc
);

    logic [MUL_A_W+MUL_B_W-1:0] prod;
    logic [ACC_W-1:0]           addend;
    logic [ACC_W-1:0]           acc_reg;
    logic [ACC_W-1:0]           acc_next;

    always_comb
    begin
        prod     = a * b;
        addend   = ctrl.shift16 ? ACC_W'({prod, 16'd0}) : ACC_W'(prod);
        acc_next = (ctrl.load ? '0 : acc_reg) + addend;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

/* rtl/core/sebd_sqrt.sv */
// Bit-pair integer square root, one result bit per cycle.
module sebd_sqrt
    import sebd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] operand,
    output sqrt_stat_t  stat,
    output logic [31:0] root
);

    logic [63:0] op_reg;
    logic [34:0] rem_reg;
    logic [31:0] root_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [34:0] rem_shift;
    logic [34:0] trial;

    always_comb
    begin
        rem_shift = {rem_reg[32:0], op_reg[63:62]};
        trial     = {1'b0, root_reg, 2'b01};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg   <= operand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            op_reg <= {op_reg[61:0], 2'b00};
            if (rem_shift >= trial)
            begin
                rem_reg  <= rem_shift - trial;
                root_reg <= {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_shift;
                root_reg <= {root_reg[30:0], 1'b0};
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg;

endmodule

/* rtl/core/spectral_energy_burst_detector.sv */
// Top level of the spectral energy burst detector: sequencer, state and ports.
//
// One beat on the input channel carries a band energy (unsigned Q16.16) and a
// millisecond timestamp; exactly one result beat follows. The block works on
// one item at a time: input stall is high from acceptance until the result
// has been moved into the output register, which may then wait for the
// consumer while the next item is already taken. An item whose gradient
// fails the 3-sigma test skips the mean and variance update, whose 32-step
// square root for sigma is the bulk of the work. The modulo step on the
// ring position takes an extra subtraction when the position wraps round
// the span, and may repeat it on the first item after the gradient span is
// lowered. A full output register held by a stalled consumer holds the
// finished item in the output state. All products go through one shared
// 48x17 multiplier with a registered accumulator; the 32x32 square of the
// deviation is done as two partial products. The ring of integrator values
// is a RAM with one valid bit per entry, so it reads as zero after reset
// without a clearing pass.
// Configuration is written over a separate index/data port that is always
// ready; write it only while the block is idle.
module spectral_energy_burst_detector
    import sebd_pkg::*;
#(
    parameter int GRADIENT_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] energy,
    input  logic [47:0] now_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] energy_echo,
    output logic [31:0] gradient,
    output logic [31:0] alarm_limit,
    output logic [31:0] grad_avg,
    output logic [31:0] sigma,
    output logic        hold_on,
    output logic        hold_rise,
    output logic        alarm_on,
    output logic        alarm_rise,
    output logic        report_due,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int AW = $clog2(GRADIENT_DEPTH);
    localparam int CW = $clog2(GRADIENT_DEPTH + 1);
    localparam int SW = (CW > 6) ? CW : 6;

    // configuration
    logic [31:0] jump_thr_reg;
    logic [31:0] latch_dur_reg;
    logic [16:0] leak_reg;
    logic [5:0]  span_cfg_reg;
    logic [16:0] weight_reg;
    logic [15:0] gain_reg;
    logic [31:0] gap_reg;

    // item state
    seq_state_t  state_reg, state_next;
    logic [31:0] energy_reg, energy_next;
    logic [47:0] now_reg, now_next;
    logic [CW-1:0] mod_reg, mod_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [GRADIENT_DEPTH-1:0] rvalid_bits_reg, rvalid_bits_next;
    logic        full_reg, full_next;
    logic        sel_new_reg, sel_new_next;
    logic        old_valid_reg, old_valid_next;
    logic [31:0] last_energy_reg, last_energy_next;
    logic        last_valid_reg, last_valid_next;
    logic [31:0] integ_reg, integ_next;
    logic [31:0] mean_reg, mean_next;
    logic [47:0] var_reg, var_next;
    logic [31:0] sigma_reg, sigma_next;
    logic [47:0] deadline_reg, deadline_next;
    logic [47:0] last_pub_reg, last_pub_next;
    logic        latch_reg, latch_next;
    logic        danger_reg, danger_next;
    logic        lstart_reg, lstart_next;
    logic        dstart_reg, dstart_next;
    logic        pub_reg, pub_next;
    logic [31:0] grad_reg, grad_next;
    logic [31:0] thr_reg, thr_next;
    logic [31:0] dev_reg, dev_next;
    logic [47:0] dsq_reg, dsq_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic        load_out;
    logic [31:0] o_energy_reg, o_grad_reg, o_thr_reg, o_mean_reg, o_sigma_reg;
    logic        o_latch_reg, o_lstart_reg, o_danger_reg, o_dstart_reg, o_pub_reg;

    // shared units
    mac_ctrl_t          mac_ctrl;
    logic [MUL_A_W-1:0] mac_a;
    logic [MUL_B_W-1:0] mac_b;
    logic [ACC_W-1:0]   acc;
    logic               sq_start;
    logic [63:0]        sq_operand;
    sqrt_stat_t         sq_stat;
    logic [31:0]        sq_root;

    logic          ram_we;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;

    // derived configuration
    logic [16:0]   leak_eff;
    logic [16:0]   w_eff;
    logic [16:0]   w_inv;
    logic [SW-1:0] span_wide;
    logic [CW-1:0] span_eff;

    // per-state working values
    logic          accept;
    logic [AW-1:0] oldest;
    logic [33:0]   integ_sum;
    logic signed [33:0] rise;
    logic [48:0]   dl_sum;
    logic [31:0]   old_val;
    logic [31:0]   absdiff;
    logic [33:0]   three_sigma;
    logic [31:0]   mean_new;
    logic [40:0]   thr_sum;
    logic          gap_ok;
    logic          latch_kept;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        leak_eff  = (leak_reg > ONE_Q16) ? ONE_Q16 : leak_reg;
        w_eff     = (weight_reg > ONE_Q16) ? ONE_Q16 : weight_reg;
        w_inv     = ONE_Q16 - w_eff;
        span_wide = SW'(span_cfg_reg);
        if (span_wide < SW'(2))
        begin
            span_eff = CW'(2);
        end
        else if (span_wide > SW'(GRADIENT_DEPTH))
        begin
            span_eff = CW'(GRADIENT_DEPTH);
        end
        else
        begin
            span_eff = span_wide[CW-1:0];
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jump_thr_reg  <= 32'd655360;
            latch_dur_reg <= 32'd500;
            leak_reg      <= 17'd58982;
            span_cfg_reg  <= 6'd8;
            weight_reg    <= 17'd3277;
            gain_reg      <= 16'd768;
            gap_reg       <= 32'd1000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_JUMP_THRESHOLD: jump_thr_reg  <= cfg_data;
                CFG_LATCH_DURATION: latch_dur_reg <= cfg_data;
                CFG_LEAK_FACTOR:    leak_reg      <= cfg_data[16:0];
                CFG_GRADIENT_SPAN:  span_cfg_reg  <= cfg_data[5:0];
                CFG_EWMA_WEIGHT:    weight_reg    <= cfg_data[16:0];
                CFG_DANGER_GAIN:    gain_reg      <= cfg_data[15:0];
                CFG_PUBLISH_GAP:    gap_reg       <= cfg_data;
                default:            ;
            endcase
        end
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    // sequencer: next state, datapath selects and state updates
    always_comb
    begin
        state_next       = state_reg;
        energy_next      = energy_reg;
        now_next         = now_reg;
        mod_next         = mod_reg;
        pos_next         = pos_reg;
        fill_next        = fill_reg;
        rvalid_bits_next = rvalid_bits_reg;
        full_next        = full_reg;
        sel_new_next     = sel_new_reg;
        old_valid_next   = old_valid_reg;
        last_energy_next = last_energy_reg;
        last_valid_next  = last_valid_reg;
        integ_next       = integ_reg;
        mean_next        = mean_reg;
        var_next         = var_reg;
        sigma_next       = sigma_reg;
        deadline_next    = deadline_reg;
        last_pub_next    = last_pub_reg;
        latch_next       = latch_reg;
        danger_next      = danger_reg;
        lstart_next      = lstart_reg;
        dstart_next      = dstart_reg;
        pub_next         = pub_reg;
        grad_next        = grad_reg;
        thr_next         = thr_reg;
        dev_next         = dev_reg;
        dsq_next         = dsq_reg;
        load_out         = 1'b0;

        mac_ctrl   = '0;
        mac_a      = '0;
        mac_b      = '0;
        sq_start   = 1'b0;
        sq_operand = {var_reg, 16'd0};
        ram_we     = 1'b0;

        oldest      = full_reg ? mod_reg[AW-1:0] : '0;
        integ_sum   = {1'b0, acc[48:16]} + {2'b00, energy_reg};
        rise        = $signed({2'b00, energy_reg}) - $signed({2'b00, last_energy_reg});
        dl_sum      = {1'b0, now_reg} + {17'd0, latch_dur_reg};
        old_val     = sel_new_reg ? integ_reg : (old_valid_reg ? ram_rdata : 32'd0);
        absdiff     = (grad_reg >= mean_reg) ? grad_reg - mean_reg : mean_reg - grad_reg;
        three_sigma = {2'b00, sigma_reg} + {1'b0, sigma_reg, 1'b0};
        mean_new    = acc[47:16];
        thr_sum     = {9'd0, mean_reg} + {1'b0, acc[47:8]};
        gap_ok      = (last_pub_reg == '0) || (gap_reg == '0) || (now_reg < last_pub_reg)
                      || ((now_reg - last_pub_reg) >= {16'd0, gap_reg});
        latch_kept  = latch_reg && !(now_reg >= deadline_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    energy_next  = energy;
                    now_next     = now_ms;
                    mod_next     = CW'(pos_reg) + CW'(1);
                    mac_ctrl.en   = 1'b1;
                    mac_ctrl.load = 1'b1;
                    mac_a        = {16'd0, integ_reg};
                    mac_b        = leak_eff;
                    state_next   = ST_MOD;
                end
            end
            ST_MOD:
            begin
                // wrap the next position into the current span
                if (mod_reg >= span_eff)
                begin
                    mod_next = mod_reg - span_eff;
                end
                else
                begin
                    state_next = ST_LATCH;
                end
            end
            ST_LATCH:
            begin
                lstart_next = 1'b0;
                latch_next  = latch_kept;
                if (last_valid_reg && (rise > $signed({{2{jump_thr_reg[31]}}, jump_thr_reg})))
                begin
                    latch_next    = 1'b1;
                    deadline_next = dl_sum[48] ? MAX48 : dl_sum[47:0];
                end
                lstart_next      = !latch_reg && latch_next;
                last_energy_next = energy_reg;
                last_valid_next  = 1'b1;
                integ_next       = (integ_sum[33:32] != 2'b00) ? 32'hFFFF_FFFF
                                                               : integ_sum[31:0];
                ram_we           = 1'b1;
                rvalid_bits_next[pos_reg] = 1'b1;
                full_next        = (fill_reg >= span_eff);
                oldest           = full_next ? mod_reg[AW-1:0] : '0;
                sel_new_next     = (oldest == pos_reg);
                old_valid_next   = rvalid_bits_reg[oldest];
                if (!full_next)
                begin
                    fill_next = fill_reg + CW'(1);
                end
                state_next = ST_GRAD;
            end
            ST_GRAD:
            begin
                grad_next  = (integ_reg > old_val) ? integ_reg - old_val : 32'd0;
                state_next = ST_ZTEST;
            end
            ST_ZTEST:
            begin
                if ({2'b00, absdiff} <= three_sigma)
                begin
                    mac_ctrl.en   = 1'b1;
                    mac_ctrl.load = 1'b1;
                    mac_a        = {16'd0, grad_reg};
                    mac_b        = w_eff;
                    state_next   = ST_MEAN_B;
                end
                else
                begin
                    state_next = ST_THR;
                end
            end
            ST_MEAN_B:
            begin
                mac_ctrl.en = 1'b1;
                mac_a      = {16'd0, mean_reg};
                mac_b      = w_inv;
                state_next = ST_MEAN_C;
            end
            ST_MEAN_C:
            begin
                mean_next  = mean_new;
                dev_next   = (grad_reg >= mean_new) ? grad_reg - mean_new : mean_new - grad_reg;
                state_next = ST_DSQ_A;
            end
            ST_DSQ_A:
            begin
                mac_ctrl.en   = 1'b1;
                mac_ctrl.load = 1'b1;
                mac_a        = {16'd0, dev_reg};
                mac_b        = {1'b0, dev_reg[15:0]};
                state_next   = ST_DSQ_B;
            end
            ST_DSQ_B:
            begin
                mac_ctrl.en      = 1'b1;
                mac_ctrl.shift16 = 1'b1;
                mac_a           = {16'd0, dev_reg};
                mac_b           = {1'b0, dev_reg[31:16]};
                state_next      = ST_DSQ_C;
            end
            ST_DSQ_C:
            begin
                dsq_next   = acc[63:16];
                state_next = ST_VAR_A;
            end
            ST_VAR_A:
            begin
                mac_ctrl.en   = 1'b1;
                mac_ctrl.load = 1'b1;
                mac_a        = dsq_reg;
                mac_b        = w_eff;
                state_next   = ST_VAR_B;
            end
            ST_VAR_B:
            begin
                mac_ctrl.en = 1'b1;
                mac_a      = var_reg;
                mac_b      = w_inv;
                state_next = ST_VAR_C;
            end
            ST_VAR_C:
            begin
                // weights sum to one, so the blend stays within 48 bits
                var_next   = acc[63:16];
                sq_start   = 1'b1;
                sq_operand = {acc[63:16], 16'd0};
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (sq_stat.done)
                begin
                    sigma_next = (sq_root < SIGMA_FLOOR) ? SIGMA_FLOOR : sq_root;
                    state_next = ST_THR;
                end
            end
            ST_THR:
            begin
                mac_ctrl.en   = 1'b1;
                mac_ctrl.load = 1'b1;
                mac_a        = {16'd0, sigma_reg};
                mac_b        = {1'b0, gain_reg};
                state_next   = ST_THR2;
            end
            ST_THR2:
            begin
                thr_next    = (thr_sum[40:32] != '0) ? 32'hFFFF_FFFF : thr_sum[31:0];
                danger_next = full_reg && (grad_reg > thr_next);
                dstart_next = !danger_reg && danger_next;
                pub_next    = danger_next && latch_reg && gap_ok;
                if (danger_next && latch_reg && gap_ok)
                begin
                    last_pub_next = now_reg;
                end
                pos_next   = mod_reg[AW-1:0];
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // hold until the output register is free or being emptied
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        ram_raddr = oldest;
        if (state_reg == ST_LATCH)
        begin
            ram_raddr = full_next ? mod_reg[AW-1:0] : '0;
        end

        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            pos_reg         <= '0;
            fill_reg        <= '0;
            rvalid_bits_reg <= '0;
            last_energy_reg <= '0;
            last_valid_reg  <= 1'b0;
            integ_reg       <= '0;
            mean_reg        <= '0;
            var_reg         <= VAR_RESET;
            sigma_reg       <= SIGMA_RESET;
            deadline_reg    <= '0;
            last_pub_reg    <= '0;
            latch_reg       <= 1'b0;
            danger_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            pos_reg         <= pos_next;
            fill_reg        <= fill_next;
            rvalid_bits_reg <= rvalid_bits_next;
            last_energy_reg <= last_energy_next;
            last_valid_reg  <= last_valid_next;
            integ_reg       <= integ_next;
            mean_reg        <= mean_next;
            var_reg         <= var_next;
            sigma_reg       <= sigma_next;
            deadline_reg    <= deadline_next;
            last_pub_reg    <= last_pub_next;
            latch_reg       <= latch_next;
            danger_reg      <= danger_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload of the item at work and of the waiting result
    always_ff @(posedge clk)
    begin
        energy_reg    <= energy_next;
        now_reg       <= now_next;
        mod_reg       <= mod_next;
        full_reg      <= full_next;
        sel_new_reg   <= sel_new_next;
        old_valid_reg <= old_valid_next;
        lstart_reg    <= lstart_next;
        dstart_reg    <= dstart_next;
        pub_reg       <= pub_next;
        grad_reg      <= grad_next;
        thr_reg       <= thr_next;
        dev_reg       <= dev_next;
        dsq_reg       <= dsq_next;
        if (load_out)
        begin
            o_energy_reg <= energy_reg;
            o_grad_reg   <= grad_reg;
            o_thr_reg    <= thr_reg;
            o_mean_reg   <= mean_reg;
            o_sigma_reg  <= sigma_reg;
            o_latch_reg  <= latch_reg;
            o_lstart_reg <= lstart_reg;
            o_danger_reg <= danger_reg;
            o_dstart_reg <= dstart_reg;
            o_pub_reg    <= pub_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign energy_echo = o_energy_reg;
    assign gradient    = o_grad_reg;
    assign alarm_limit = o_thr_reg;
    assign grad_avg    = o_mean_reg;
    assign sigma       = o_sigma_reg;
    assign hold_on     = o_latch_reg;
    assign hold_rise   = o_lstart_reg;
    assign alarm_on    = o_danger_reg;
    assign alarm_rise  = o_dstart_reg;
    assign report_due  = o_pub_reg;

    sebd_mac u_mac (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .a    (mac_a),
        .b    (mac_b),
        .acc  (acc)
    );

    sebd_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sq_start),
        .operand (sq_operand),
        .stat    (sq_stat),
        .root    (sq_root)
    );

    sebd_ram #(
        .WIDTH (32),
        .DEPTH (GRADIENT_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg),
        .wdata (integ_next),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sigma never drops below its floor
    a_sigma_floor: assert property (@(posedge clk) disable iff (!rst_n)
        sigma_reg >= SIGMA_FLOOR)
        else $error("sigma below floor");

    // fill count never passes the ring depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(GRADIENT_DEPTH))
        else $error("ring fill out of range");

    // an accepted beat makes the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("not busy after accept");

    // the square root only runs while the sequencer waits for it
    a_sqrt_owner: assert property (@(posedge clk) disable iff (!rst_n)
        sq_stat.busy |-> state_reg == ST_SQRT)
        else $error("square root busy outside its state");

endmodule

/* dv/tb_spectral_energy_burst_detector.sv */
// Self-checking testbench for the spectral energy burst detector.
`timescale 1ns / 1ps

module tb_spectral_energy_burst_detector;
    import sebd_pkg::*;

    localparam int RING_DEPTH = 32;
    // Cycles with no beat on any channel before the run is declared hung.
    localparam int HANG_LIMIT = 4000;
    // Settling time after the last result: one full item with its square root.
    localparam int TAIL_CYCLES = 64;

    // One result beat as the block should present it.
    typedef struct {
        logic [31:0] energy_echo;
        logic [31:0] gradient;
        logic [31:0] alarm_limit;
        logic [31:0] grad_avg;
        logic [31:0] sigma;
        logic        hold_on;
        logic        hold_rise;
        logic        alarm_on;
        logic        alarm_rise;
        logic        report_due;
    } window_verdict_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] energy;
    logic [47:0] now_ms;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] energy_echo;
    logic [31:0] gradient;
    logic [31:0] alarm_limit;
    logic [31:0] grad_avg;
    logic [31:0] sigma;
    logic        hold_on;
    logic        hold_rise;
    logic        alarm_on;
    logic        alarm_rise;
    logic        report_due;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    spectral_energy_burst_detector #(.GRADIENT_DEPTH(RING_DEPTH)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .energy      (energy),
        .now_ms      (now_ms),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .energy_echo (energy_echo),
        .gradient    (gradient),
        .alarm_limit (alarm_limit),
        .grad_avg    (grad_avg),
        .sigma       (sigma),
        .hold_on     (hold_on),
        .hold_rise   (hold_rise),
        .alarm_on    (alarm_on),
        .alarm_rise  (alarm_rise),
        .report_due  (report_due),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow copy of the detector: its registers and its running state.
    // ------------------------------------------------------------------
    longint          jump_thr_q;      // signed Q16.16, sign extended
    logic [31:0]     latch_len_q;
    logic [16:0]     leak_q;
    logic [5:0]      span_q;
    logic [16:0]     weight_q;
    logic [15:0]     gain_q;
    logic [31:0]     pub_gap_q;

    logic [31:0]     integ_ring [RING_DEPTH];
    int unsigned     ring_pos;
    int unsigned     ring_count;
    logic [31:0]     prev_energy;
    bit              prev_energy_seen;
    logic [31:0]     integ_now;
    logic [31:0]     mean_now;
    longint unsigned var_now;
    logic [31:0]     sigma_now;
    longint unsigned latch_until;
    longint unsigned last_pub_ms;
    bit              latch_on;
    bit              danger_on;

    window_verdict_t pending_verdicts[$];
    bit              failed;
    bit              quiet;           // no idling on either side while set
    int unsigned     idle_cycles;
    longint unsigned clock_ms;        // running timestamp for the stimulus
    logic [31:0]     energy_level;    // running energy for burst shaping

    function automatic logic [31:0] root_q32(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r[31:0];
    endfunction

    function automatic logic [31:0] sigma_from_var(longint unsigned v);
        logic [31:0] s;
        s = root_q32((v & 64'hFFFF_FFFF_FFFF) << 16);
        return (s < SIGMA_FLOOR) ? SIGMA_FLOOR : s;
    endfunction

    function automatic longint unsigned cap_one(logic [16:0] x);
        return (x > ONE_Q16) ? 64'd65536 : 64'(x);
    endfunction

    function automatic void shadow_reset();
        jump_thr_q  = 655360;
        latch_len_q = 500;
        leak_q      = 58982;
        span_q      = 8;
        weight_q    = 3277;
        gain_q      = 768;
        pub_gap_q   = 1000;
        foreach (integ_ring[i]) integ_ring[i] = '0;
        ring_pos         = 0;
        ring_count       = 0;
        prev_energy      = '0;
        prev_energy_seen = 0;
        integ_now        = '0;
        mean_now         = '0;
        var_now          = 64'(VAR_RESET);
        sigma_now        = SIGMA_RESET;
        latch_until      = 0;
        last_pub_ms      = 0;
        latch_on         = 0;
        danger_on        = 0;
    endfunction

    function automatic void shadow_write(logic [2:0] idx, logic [31:0] data);
        unique case (idx)
            CFG_JUMP_THRESHOLD: jump_thr_q  = longint'(signed'(data));
            CFG_LATCH_DURATION: latch_len_q = data;
            CFG_LEAK_FACTOR:    leak_q      = data[16:0];
            CFG_GRADIENT_SPAN:  span_q      = data[5:0];
            CFG_EWMA_WEIGHT:    weight_q    = data[16:0];
            CFG_DANGER_GAIN:    gain_q      = data[15:0];
            CFG_PUBLISH_GAP:    pub_gap_q   = data;
            default: ;
        endcase
    endfunction

    // Advance the shadow by one window and return the verdict it yields.
    function automatic window_verdict_t assess_window(logic [31:0] e, logic [47:0] t);
        window_verdict_t v;
        bit              had_latch;
        bit              had_danger;
        bit              ring_full;
        bit              gap_over;
        bit              pub;
        int unsigned     span;
        int unsigned     pos;
        int unsigned     oldest;
        longint unsigned leak;
        longint unsigned w;
        longint unsigned now;
        longint unsigned acc;
        longint unsigned dev;
        longint unsigned dev_sq;
        logic [31:0]     grad;
        logic [31:0]     thr;

        now        = 64'(t);
        had_latch  = latch_on;
        had_danger = danger_on;
        leak       = cap_one(leak_q);
        w          = cap_one(weight_q);
        span       = span_q;
        if (span < 2) span = 2;
        if (span > RING_DEPTH) span = RING_DEPTH;
        pos = (ring_pos < RING_DEPTH) ? ring_pos : 0;

        // latch: expire, then re-arm on a large enough rise
        if (latch_on && now >= latch_until) latch_on = 0;
        if (prev_energy_seen && (longint'(e) - longint'(prev_energy)) > jump_thr_q) begin
            latch_on    = 1;
            acc         = now + 64'(latch_len_q);
            latch_until = (acc > 64'hFFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF : acc;
        end
        prev_energy      = e;
        prev_energy_seen = 1;

        // leaky integrator into the ring, saturating
        acc       = ((leak * 64'(integ_now)) >> 16) + 64'(e);
        integ_now = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
        integ_ring[pos] = integ_now;

        ring_full = (ring_count >= span);
        if (!ring_full) ring_count++;
        oldest = ring_full ? (pos + 1) % span : 0;
        grad   = (integ_now > integ_ring[oldest]) ? integ_now - integ_ring[oldest] : '0;

        // statistics move only when the gradient is within three sigma
        sigma_now = sigma_from_var(var_now);
        dev = (grad >= mean_now) ? 64'(grad - mean_now) : 64'(mean_now - grad);
        if (dev <= 3 * 64'(sigma_now)) begin
            acc      = (w * 64'(grad) + (64'd65536 - w) * 64'(mean_now)) >> 16;
            mean_now = acc[31:0];
            dev      = (grad >= mean_now) ? 64'(grad - mean_now) : 64'(mean_now - grad);
            dev_sq   = (dev * dev) >> 16;
            var_now  = (w * dev_sq + (64'd65536 - w) * (var_now & 64'hFFFF_FFFF_FFFF)) >> 16;
            if (var_now > 64'hFFFF_FFFF_FFFF) var_now = 64'hFFFF_FFFF_FFFF;
            sigma_now = sigma_from_var(var_now);
        end

        acc       = 64'(mean_now) + ((64'(gain_q) * 64'(sigma_now)) >> 8);
        thr       = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
        danger_on = ring_full && (grad > thr);
        ring_pos  = (pos + 1) % span;

        // rate limit on publishing; time running backwards counts as elapsed
        gap_over = (last_pub_ms == 0) || (pub_gap_q == 0) || (now < last_pub_ms) ||
                   ((now - last_pub_ms) >= 64'(pub_gap_q));
        pub = danger_on && latch_on && gap_over;
        if (pub) last_pub_ms = now;

        v.energy_echo = e;
        v.gradient    = grad;
        v.alarm_limit = thr;
        v.grad_avg    = mean_now;
        v.sigma       = sigma_now;
        v.hold_on     = latch_on;
        v.hold_rise   = !had_latch && latch_on;
        v.alarm_on    = danger_on;
        v.alarm_rise  = !had_danger && danger_on;
        v.report_due  = pub;
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Send one window beat; valid stays high afterwards so back-to-back
    // beats never lower and raise it in the same step.
    task automatic send_window(logic [31:0] e, logic [47:0] t);
        int unsigned gap;
        if (!quiet && $urandom_range(99) < 21) begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        energy   <= e;
        now_ms   <= t;
        do @(posedge clk); while (in_stall);
        pending_verdicts.push_back(assess_window(e, t));
    endtask

    // Drop valid and hold until every result is back.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_verdicts.size() != 0) @(posedge clk);
    endtask

    // Program all seven registers with the block idle; hold valid high
    // across consecutive writes and drop it once at the end.
    task automatic program_regs(logic [31:0] jthr, logic [31:0] llen, logic [31:0] leak,
                                logic [31:0] span, logic [31:0] wgt, logic [31:0] gain,
                                logic [31:0] gap);
        logic [31:0] vals [7];
        logic [2:0]  idx [7];
        drain_results();
        vals = '{jthr, llen, leak, span, wgt, gain, gap};
        idx  = '{CFG_JUMP_THRESHOLD, CFG_LATCH_DURATION, CFG_LEAK_FACTOR,
                 CFG_GRADIENT_SPAN, CFG_EWMA_WEIGHT, CFG_DANGER_GAIN, CFG_PUBLISH_GAP};
        for (int i = 0; i < 7; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            do @(posedge clk); while (!cfg_ready);
            shadow_write(idx[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Next energy of a burst-shaped trace: mostly a drifting floor, with
    // jumps, drops and the odd fully random value.
    function automatic logic [31:0] next_energy();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 55)
            energy_level = 32'($urandom_range(32'h0000_4000, 32'h0008_0000));
        else if (pick < 72)
            energy_level = energy_level + 32'($urandom_range(32'h000A_0000, 32'h0100_0000));
        else if (pick < 82)
            energy_level = energy_level >> $urandom_range(1, 8);
        else
            energy_level = $urandom;
        return energy_level;
    endfunction

    // Next timestamp: mostly forward steps, sometimes a leap, a step back
    // or an arbitrary 48-bit value.
    function automatic logic [47:0] next_time();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 80)
            clock_ms = clock_ms + $urandom_range(1, 400);
        else if (pick < 88)
            clock_ms = clock_ms + $urandom_range(1000, 100000);
        else if (pick < 94)
            clock_ms = (clock_ms > 2000) ? clock_ms - $urandom_range(1, 2000) : 0;
        else
            clock_ms = {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF;
        return clock_ms[47:0];
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: zero input first, then a jump, extremes of both fields.
    task automatic test_reset_defaults();
        send_window(32'h0, 48'h0);
        send_window(32'h0010_0000, 48'd10);          // rise above the default threshold
        send_window(32'hFFFF_FFFF, 48'd20);          // integrator saturates
        send_window(32'hFFFF_FFFF, 48'd30);
        send_window(32'h0, 48'd600);                 // latch times out
        send_window(32'h5555_5555, 48'hAAAA_AAAA_AAAA);
        send_window(32'hAAAA_AAAA, 48'h5555_5555_5555);
        send_window(32'h0, 48'hFFFF_FFFF_FFFF);
    endtask

    // Extremes of every register, including values above one and spans out
    // of range; deadline saturation near the top of the time range.
    task automatic test_register_extremes();
        program_regs(32'h8000_0000, 32'hFFFF_FFFF, 32'h0001_FFFF, 32'd0,
                     32'h0001_FFFF, 32'd0, 32'd0);
        send_window(32'h0, 48'hFFFF_FFFF_FF00);
        send_window(32'h1, 48'hFFFF_FFFF_FFF0);      // deadline saturates
        send_window(32'hFFFF_FFFF, 48'd5);           // time going backwards
        send_window(32'h0, 48'd6);
        program_regs(32'h7FFF_FFFF, 32'd0, 32'd0, 32'd63, 32'd0, 32'hFFFF,
                     32'hFFFF_FFFF);                 // zero weight: statistics frozen
        for (int i = 0; i < 4; i++) send_window($urandom, 48'(100 + i));
        program_regs(32'h0, 32'd1, 32'd65536, 32'd1, 32'd65536, 32'd1, 32'd1);
        for (int i = 0; i < 4; i++) send_window(32'(i) << 20, 48'(200 + i));
    endtask

    // Span lowered while the ring is still filling.
    task automatic test_span_change();
        program_regs(32'd655360, 32'd500, 32'd58982, 32'd32, 32'd3277, 32'd768, 32'd1000);
        for (int i = 0; i < 5; i++) send_window(32'h0002_0000 * (i + 1), 48'(300 + i));
        program_regs(32'd655360, 32'd500, 32'd58982, 32'd2, 32'd3277, 32'd768, 32'd1000);
        for (int i = 0; i < 3; i++) send_window(32'h0004_0000, 48'(400 + i));
    endtask

    // Random register settings, each followed by a run of burst-shaped windows.
    task automatic test_random_traffic();
        int unsigned phase_len;
        logic [31:0] jthr;
        logic [31:0] span;
        for (int ph = 0; ph < 9; ph++) begin
            jthr = ($urandom_range(9) == 0) ? $urandom
                                            : 32'($urandom_range(0, 32'h0020_0000));
            span = ($urandom_range(9) == 0) ? $urandom_range(0, 63) : $urandom_range(2, 32);
            program_regs(jthr, $urandom_range(0, 3000),
                         ($urandom_range(9) == 0) ? $urandom_range(0, 32'h1FFFF)
                                                  : $urandom_range(40000, 65536),
                         span,
                         ($urandom_range(9) == 0) ? $urandom_range(0, 32'h1FFFF)
                                                  : $urandom_range(1000, 20000),
                         ($urandom_range(9) == 0) ? $urandom_range(0, 65535)
                                                  : $urandom_range(128, 1024),
                         ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 2000));
            phase_len = $urandom_range(40, 70);
            quiet = (ph == 4);                       // one long stretch with no idling
            for (int i = 0; i < phase_len; i++) send_window(next_energy(), next_time());
            quiet = 0;
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: random stall and the result checker
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        out_stall <= !quiet && ($urandom_range(99) < 21);
    end

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            failed = 1;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk) begin
        window_verdict_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_verdicts.size() == 0) begin
                failed = 1;
                $display("%0t: result beat with nothing expected, energy_echo actual %0h",
                         $time, energy_echo);
            end
            else begin
                want = pending_verdicts.pop_front();
                check_field("energy_echo", want.energy_echo, energy_echo);
                check_field("gradient", want.gradient, gradient);
                check_field("alarm_limit", want.alarm_limit, alarm_limit);
                check_field("grad_avg", want.grad_avg, grad_avg);
                check_field("sigma", want.sigma, sigma);
                check_field("hold_on", want.hold_on, hold_on);
                check_field("hold_rise", want.hold_rise, hold_rise);
                check_field("alarm_on", want.alarm_on, alarm_on);
                check_field("alarm_rise", want.alarm_rise, alarm_rise);
                check_field("report_due", want.report_due, report_due);
            end
        end
    end

    // Hang watchdog: count cycles with no beat on any channel.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= HANG_LIMIT) begin
            $display("spectral_energy_burst_detector: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        energy       = '0;
        now_ms       = '0;
        out_stall    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_JUMP_THRESHOLD;
        cfg_data     = '0;
        failed       = 0;
        quiet        = 0;
        idle_cycles  = 0;
        clock_ms     = 1000;
        energy_level = 32'h0001_0000;
        shadow_reset();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_register_extremes();
        test_span_change();
        test_random_traffic();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_verdicts.size() != 0) begin
            failed = 1;
            $display("%0t: %0d results never arrived", $time, pending_verdicts.size());
        end
        if (!failed)
            $display("spectral_energy_burst_detector: match");
        else
            $display("spectral_energy_burst_detector: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/sebd_pkg.sv
rtl/core/sebd_ram.sv
rtl/core/sebd_mac.sv
rtl/core/sebd_sqrt.sv
rtl/core/spectral_energy_burst_detector.sv
dv/tb_spectral_energy_burst_detector.sv
